// ----- rtl/zero_escape_rle_decoder_top_macros.svh -----
// Assertion macros shared by the zero-escape run-length decoder modules.
`ifndef ZERO_ESCAPE_RLE_DECODER_TOP_MACROS_SVH
`define ZERO_ESCAPE_RLE_DECODER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ZERD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("zerd: assertion failed");
`define ZERD_NEVER(lbl, cond) \
	`ZERD_ASSERT(lbl, !(cond))
`else
`define ZERD_ASSERT(lbl, prop)
`define ZERD_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/zerd_pkg.sv -----
// Types and constants of the zero-escape run-length decoder.
package zerd_pkg;
	localparam int unsigned CNT_W           = 27;
	localparam int unsigned MAX_PLAIN_BYTES = 67108864;
	localparam logic [CNT_W-1:0] MAX_PLAIN  = CNT_W'(MAX_PLAIN_BYTES);

	// Register indexes of the write port
	localparam int unsigned   CFG_IDX_W      = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PACKED_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAIN_LENGTH  = 1'b1;

	// Result queue geometry
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0]       run_value;
		logic [CNT_W-1:0] run_length;
		logic             run_last;
	} run_t;

	typedef enum logic [2:0] {
		PH_LIT = 3'b001,
		PH_VAL = 3'b010,
		PH_CNT = 3'b100
	} phase_t;

	// Words written to the result queue in one cycle
	typedef struct packed {
		logic [1:0] num;
		run_t       first;
		run_t       second;
	} push_t;
endpackage

// ----- rtl/zero_escape_rle_decoder_top.sv -----
// Top level of the zero-escape run-length decoder.
// Decodes one packed byte per clock: a byte is taken into an input register, decoded
// there combinationally against the frame counters, and its results (a decoded run
// and, at the end of a frame, the padding run flagged run_last) go into a four-word
// result queue. A byte is taken every cycle while the queue holds at most two words;
// the queue drains one word per cycle while run_ready is high, so a byte that both
// yields a run and closes a frame puts two words in it. A byte passes the input
// register, then the queue. Write packed_length and plain_length only while no byte
// is in flight; a write takes effect at once, also in the middle of a frame.
`include "zero_escape_rle_decoder_top_macros.svh"
module zero_escape_rle_decoder_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [zerd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [zerd_pkg::CNT_W-1:0]         cfg_data,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  zerd_pkg::item_t                    item,
	output logic                               run_valid,
	input  logic                               run_ready,
	output zerd_pkg::run_t                     run
);
	localparam int unsigned W = zerd_pkg::CNT_W;

	logic [W-1:0]     packed_len_q;
	logic [W-1:0]     plain_len_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	zerd_pkg::phase_t phase_q;
	logic [7:0]       held_q;
	logic [W-1:0]     rd_cnt_q;
	logic [W-1:0]     wr_cnt_q;

	logic             room2;
	logic             adv;
	logic [W-1:0]     plain;
	logic             has_room;
	logic             active;
	logic [W-1:0]     room;
	logic [W-1:0]     byte_w;
	logic [W-1:0]     esc_cnt;
	logic             hit;
	logic [7:0]       hit_value;
	logic [W-1:0]     hit_len;
	zerd_pkg::phase_t phase_d;
	logic [7:0]       held_d;
	logic [W-1:0]     rd_inc;
	logic             frame_end;
	logic [W-1:0]     pad;
	zerd_pkg::run_t   run_word;
	zerd_pkg::run_t   pad_word;
	zerd_pkg::push_t  push;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packed_len_q <= '0;
			plain_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				zerd_pkg::REG_PACKED_LENGTH: packed_len_q <= cfg_data;
				zerd_pkg::REG_PLAIN_LENGTH:  plain_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	assign adv        = valid_s1 && room2;
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			byte_s1 <= item.in_byte;
			last_s1 <= item.in_last;
		end
	end

	// Decode of the held byte
	always_comb begin
		plain    = (plain_len_q > zerd_pkg::MAX_PLAIN) ? zerd_pkg::MAX_PLAIN : plain_len_q;
		has_room = wr_cnt_q < plain;
		active   = (rd_cnt_q < packed_len_q) && has_room;
		room     = plain - wr_cnt_q;
		byte_w   = W'(byte_s1);
		esc_cnt  = (byte_w < room) ? byte_w : room;

		hit       = 1'b0;
		hit_value = byte_s1;
		hit_len   = W'(1);
		phase_d   = phase_q;
		held_d    = held_q;
		if (active) begin
			unique case (phase_q)
				zerd_pkg::PH_VAL: begin
					held_d  = byte_s1;
					phase_d = zerd_pkg::PH_CNT;
				end
				zerd_pkg::PH_CNT: begin
					hit       = esc_cnt != '0;
					hit_value = held_q;
					hit_len   = esc_cnt;
					phase_d   = zerd_pkg::PH_LIT;
				end
				default: begin
					if (byte_s1 != 8'd0) begin
						hit     = 1'b1;
						phase_d = zerd_pkg::PH_LIT;
					end else begin
						phase_d = zerd_pkg::PH_VAL;
					end
				end
			endcase
		end

		rd_inc    = rd_cnt_q + W'(1);
		frame_end = last_s1 || (rd_inc >= packed_len_q);
		// a run never exceeds the room left, so the pad is room minus the run
		pad       = has_room ? (room - (hit ? hit_len : '0)) : '0;

		run_word.run_value  = hit_value;
		run_word.run_length = hit_len;
		run_word.run_last   = 1'b0;
		pad_word.run_value  = 8'd0;
		pad_word.run_length = pad;
		pad_word.run_last   = 1'b1;

		push.num    = adv ? (2'(hit) + 2'(frame_end)) : 2'd0;
		push.first  = hit ? run_word : pad_word;
		push.second = pad_word;
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= zerd_pkg::PH_LIT;
			held_q   <= '0;
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
		end else if (adv) begin
			if (frame_end) begin
				phase_q  <= zerd_pkg::PH_LIT;
				held_q   <= '0;
				rd_cnt_q <= '0;
				wr_cnt_q <= '0;
			end else begin
				phase_q  <= phase_d;
				held_q   <= held_d;
				rd_cnt_q <= rd_inc;
				wr_cnt_q <= wr_cnt_q + (hit ? hit_len : '0);
			end
		end
	end

	zerd_run_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run       (run)
	);

	`ZERD_ASSERT(a_phase_onehot, $onehot(phase_q))
	`ZERD_NEVER(a_empty_run_not_last, run_valid && !run.run_last && run.run_length == '0)
	`ZERD_ASSERT(a_stall_holds_byte, valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
	`ZERD_NEVER(a_escape_hit, hit && phase_q == zerd_pkg::PH_VAL)
endmodule

// ----- rtl/zerd_run_queue.sv -----
// Small result queue that takes up to two words per cycle and gives at most one.
`include "zero_escape_rle_decoder_top_macros.svh"
module zerd_run_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  zerd_pkg::push_t push,
	output logic            room2,
	output logic            run_valid,
	input  logic            run_ready,
	output zerd_pkg::run_t  run
);
	zerd_pkg::run_t                     entry_q [zerd_pkg::QDEPTH];
	logic [zerd_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [zerd_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [zerd_pkg::QCNT_W-1:0]        count_q;
	logic                               pop;
	logic [zerd_pkg::QPTR_W-1:0]        wr_ptr_b;

	assign pop       = run_valid && run_ready;
	assign run_valid = count_q != '0;
	assign run       = entry_q[rd_ptr_q];
	assign room2     = count_q <= zerd_pkg::QCNT_W'(zerd_pkg::QDEPTH - 2);
	assign wr_ptr_b  = wr_ptr_q + zerd_pkg::QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			entry_q[wr_ptr_b] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + zerd_pkg::QPTR_W'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + zerd_pkg::QPTR_W'(1);
			end
			count_q <= count_q + zerd_pkg::QCNT_W'(push.num)
				- zerd_pkg::QCNT_W'(pop);
		end
	end

	`ZERD_NEVER(a_q_overflow, count_q > zerd_pkg::QCNT_W'(zerd_pkg::QDEPTH))
	`ZERD_NEVER(a_q_push_full, (push.num == 2'd3) || (push.num != 2'd0 && !room2))
	`ZERD_ASSERT(a_q_ptr_gap, zerd_pkg::QPTR_W'(wr_ptr_q - rd_ptr_q) == zerd_pkg::QPTR_W'(count_q))
endmodule

// ----- tb/zerd_tb_pkg.sv -----
// Scoreboard for the zero-escape run-length decoder testbench.
`timescale 1ns / 100ps
package zerd_tb_pkg;
	import zerd_pkg::*;

	class rle_scoreboard;
		logic [CNT_W-1:0] packed_len = '0;
		logic [CNT_W-1:0] plain_len  = '0;
		phase_t           phase      = PH_LIT;
		logic [7:0]       held_value = '0;
		logic [CNT_W-1:0] bytes_read = '0;
		logic [CNT_W-1:0] bytes_made = '0;
		run_t             runs_owed[$];
		int               errors        = 0;
		int               bytes_taken   = 0;
		int               runs_checked  = 0;
		int               frames_closed = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
			if (idx == REG_PACKED_LENGTH) begin
				packed_len = data;
			end else begin
				plain_len = data;
			end
		endfunction

		// Append a run to the tail of the expected list.
		function void owe_run(run_t r);
			runs_owed.insert(runs_owed.size(), r);
		endfunction

		// Decode one accepted word and queue the runs it yields.
		function void take_byte(item_t it);
			logic [CNT_W-1:0] plain;
			logic [CNT_W-1:0] room;
			logic [CNT_W-1:0] cnt;
			plain = (plain_len < MAX_PLAIN) ? plain_len : MAX_PLAIN;
			bytes_taken++;
			if (bytes_read < packed_len && bytes_made < plain) begin
				case (phase)
					PH_VAL: begin
						held_value = it.in_byte;
						phase = PH_CNT;
					end
					PH_CNT: begin
						room = plain - bytes_made;
						cnt = (CNT_W'(it.in_byte) < room) ? CNT_W'(it.in_byte) : room;
						if (cnt != 0) begin
							owe_run('{run_value: held_value, run_length: cnt,
								run_last: 1'b0});
							bytes_made += cnt;
						end
						phase = PH_LIT;
					end
					default: begin
						if (it.in_byte != 0) begin
							owe_run('{run_value: it.in_byte, run_length: CNT_W'(1),
								run_last: 1'b0});
							bytes_made += CNT_W'(1);
							phase = PH_LIT;
						end else begin
							phase = PH_VAL;
						end
					end
				endcase
			end
			bytes_read = bytes_read + 1'b1;
			if (it.in_last || bytes_read >= packed_len) begin
				// close the frame with zero padding up to the plain length
				owe_run('{run_value: 8'd0,
					run_length: (bytes_made < plain) ? plain - bytes_made : '0,
					run_last: 1'b1});
				frames_closed++;
				phase = PH_LIT;
				held_value = '0;
				bytes_read = '0;
				bytes_made = '0;
			end
		endfunction

		function void check_run(run_t got);
			run_t want;
			if (runs_owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected run: expected none, got value=%0d length=%0d last=%0d",
					$time, got.run_value, got.run_length, got.run_last);
				return;
			end
			want = runs_owed.pop_front();
			runs_checked++;
			if (got.run_value !== want.run_value) begin
				errors++;
				$display("%0t: run_value mismatch: expected %0d, got %0d",
					$time, want.run_value, got.run_value);
			end
			if (got.run_length !== want.run_length) begin
				errors++;
				$display("%0t: run_length mismatch: expected %0d, got %0d",
					$time, want.run_length, got.run_length);
			end
			if (got.run_last !== want.run_last) begin
				errors++;
				$display("%0t: run_last mismatch: expected %0d, got %0d",
					$time, want.run_last, got.run_last);
			end
		endfunction

		function int pending();
			return runs_owed.size();
		endfunction
	endclass
endpackage

// ----- tb/zero_escape_rle_decoder_top_tb.sv -----
// Self-checking testbench of the zero-escape run-length decoder top level.
`timescale 1ns / 100ps
module zero_escape_rle_decoder_top_tb;
	import zerd_pkg::*;
	import zerd_tb_pkg::*;

	localparam int               HALF_PERIOD   = 6;
	localparam int               SETTLE_CYCLES = 8;
	localparam int               HOLD_CYCLES   = 64;
	localparam int               RANDOM_BYTES  = 700;
	localparam logic [CNT_W-1:0] CNT_MAX       = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	item_t                item = '0;
	logic                 run_valid;
	logic                 run_ready;
	run_t                 run;

	rle_scoreboard sb = new();
	int  tx_gap_max = 9;
	int  rx_gap_max = 9;
	bit  hold_req = 1'b0;
	int  holds_done = 0;
	int  random_bytes = 0;

	zero_escape_rle_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.run_valid(run_valid),
		.run_ready(run_ready),
		.run(run)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		#5_000_000;
		$display("zero_escape_rle_decoder_top_tb: FAIL");
		$finish;
	end

	// Result side: draw a wait per word, or hold off for a long stretch on request.
	initial begin
		int gap;
		run_ready = 1'b0;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, rx_gap_max);
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
				holds_done++;
			end
			@(negedge clk);
			if (gap != 0) begin
				run_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			run_ready <= 1'b1;
			do @(posedge clk); while (!run_valid);
			sb.check_run(run);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic set_lengths(input logic [CNT_W-1:0] packed_len,
			input logic [CNT_W-1:0] plain_len);
		write_reg(REG_PACKED_LENGTH, packed_len);
		write_reg(REG_PLAIN_LENGTH, plain_len);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Valid stays high from one word to the next unless a gap is drawn.
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{in_byte: b, in_last: l};
		do @(posedge clk); while (!item_ready);
		sb.take_byte('{in_byte: b, in_last: l});
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// a word that yields no run may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CNT_W-1:0] pick_packed();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) return CNT_MAX;
		if (sel < 8) return CNT_W'($urandom_range(5, 60));
		if (sel < 9) return CNT_W'($urandom_range(0, 2));
		return CNT_W'($urandom);
	endfunction

	function automatic logic [CNT_W-1:0] pick_plain();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 8) return CNT_W'($urandom_range(20, 400));
		if (sel < 11) return MAX_PLAIN;
		if (sel < 13) return CNT_MAX;
		if (sel < 15) return CNT_W'($urandom);
		if (sel < 17) return CNT_W'($urandom_range(0, 3));
		return CNT_W'($urandom_range(1000, 5000));
	endfunction

	// Mostly well-formed literals and escapes, with some noise and stray frame ends.
	task automatic random_frame(input int n_bytes);
		logic [7:0] stream[$];
		int         sel;
		int         i;
		while (stream.size() < n_bytes) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				stream.insert(stream.size(), 8'($urandom_range(1, 255)));
			end else if (sel < 85) begin
				stream.insert(stream.size(), 8'd0);
				stream.insert(stream.size(), 8'($urandom_range(0, 255)));
				sel = $urandom_range(0, 9);
				if (sel < 5) stream.insert(stream.size(), 8'($urandom_range(1, 8)));
				else if (sel < 7) stream.insert(stream.size(), 8'd0);
				else stream.insert(stream.size(), 8'($urandom_range(0, 255)));
			end else begin
				stream.insert(stream.size(), 8'($urandom_range(0, 255)));
			end
		end
		for (i = 0; i < stream.size(); i++) begin
			send_byte(stream[i], (i == stream.size() - 1) || ($urandom_range(0, 49) == 0));
		end
		random_bytes += stream.size();
	endtask

	initial begin
		int n;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty packed length: every word closes a padding-only frame
		set_lengths('0, 5);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		drain();

		// widest settings: plain length clamps, escapes with extreme value and count
		set_lengths(CNT_MAX, CNT_MAX);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b1);
		drain();

		// count clamped to the space left, then output full with bytes still coming
		set_lengths(4, 3);
		send_byte(8'h07, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h09, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h04, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h06, 1'b0);
		drain();

		// escape cut off in the count phase by the packed length, then one cut off in the value phase by a last word
		set_lengths(3, 10);
		send_byte(8'h41, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h00, 1'b1);
		drain();

		// shrink the plain length mid-frame below what was already produced
		set_lengths(CNT_MAX, 10);
		send_byte(8'h00, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h08, 1'b0);
		drain();
		set_lengths(CNT_MAX, 4);
		send_byte(8'h11, 1'b1);
		drain();

		// back-pressure: receiver holds off while the sender streams without gaps
		tx_gap_max = 0;
		rx_gap_max = 0;
		set_lengths(CNT_MAX, MAX_PLAIN);
		hold_req = 1'b1;
		random_frame(60);
		drain();

		while (random_bytes < RANDOM_BYTES) begin
			tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
			rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
			set_lengths(pick_packed(), pick_plain());
			n = $urandom_range(10, 45);
			random_frame(n);
			drain();
		end

		$display("Covered %0d input words, %0d runs checked, %0d frames closed,",
			sb.bytes_taken, sb.runs_checked, sb.frames_closed);
		$display("with %0d long output hold-offs and %0d mismatches.", holds_done, sb.errors);
		if (sb.errors == 0) begin
			$display("zero_escape_rle_decoder_top_tb: PASS");
		end else begin
			$display("zero_escape_rle_decoder_top_tb: FAIL");
		end
		$finish;
	end
endmodule
